FILE: hw/rtl/srsw_pkg.sv
// shared types and constants of the selective-repeat sender window
// no dependencies
package srsw_pkg;

   localparam int MODE_W     = 2;
   localparam int KIND_W     = 3;
   localparam int SEQ_W      = 8;
   localparam int PAY_W      = 32;
   localparam int COUNT_W    = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [MODE_W-1:0]     mode_type;
   typedef logic [KIND_W-1:0]     kind_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam mode_type MODE_SEND  = 2'd0;
   localparam mode_type MODE_ACK   = 2'd1;
   localparam mode_type MODE_TIMER = 2'd2;
   localparam mode_type MODE_NONE  = 2'd3;

   localparam kind_type KIND_TRANSMIT   = 3'd0;
   localparam kind_type KIND_REFUSED    = 3'd1;
   localparam kind_type KIND_ACKED      = 3'd2;
   localparam kind_type KIND_IGNORED    = 3'd3;
   localparam kind_type KIND_RETRANSMIT = 3'd4;

   localparam csr_addr_type CSR_WINDOW_SIZE    = 2'd0;
   localparam csr_addr_type CSR_FIRST_SEQUENCE = 2'd1;

   localparam logic [3:0] WINDOW_SIZE_RESET    = 4'd4;
   localparam logic [7:0] FIRST_SEQUENCE_RESET = 8'd1;

endpackage

FILE: hw/rtl/srsw_if.sv
// valid/ready channel interfaces: send/ack/timer requests, responses, csr writes
// depends on srsw_pkg
interface srsw_req_if import srsw_pkg::*; ();
   logic             valid;
   logic             ready;
   mode_type         mode;
   logic [PAY_W-1:0] payload;
   logic [SEQ_W-1:0] ack_number;
   logic             ack_checksum_ok;
   logic [SEQ_W-1:0] timer_sequence;

   modport source (output valid, mode, payload, ack_number, ack_checksum_ok,
                   timer_sequence, input ready);
   modport sink   (input valid, mode, payload, ack_number, ack_checksum_ok,
                   timer_sequence, output ready);
endinterface

interface srsw_rsp_if import srsw_pkg::*; ();
   logic               valid;
   logic               ready;
   kind_type           out_kind;
   logic [SEQ_W-1:0]   out_sequence;
   logic [PAY_W-1:0]   out_payload;
   logic               timer_start;
   logic               timer_stop;
   logic               window_full;
   logic [COUNT_W-1:0] window_count;

   modport source (output valid, out_kind, out_sequence, out_payload, timer_start,
                   timer_stop, window_full, window_count, input ready);
   modport sink   (input valid, out_kind, out_sequence, out_payload, timer_start,
                   timer_stop, window_full, window_count, output ready);
endinterface

interface srsw_csr_if import srsw_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_addr_type          addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

FILE: hw/rtl/selective_repeat_sender_window.sv
// selective-repeat arq sender window: packet buffer in a circular memory
// a request passes the pending registers, then the response registers; an ack also passes
// the slide state, where the slide loop retires the acked front entries. A new request is
// taken only in the idle state, so one transaction is in flight; a stalled response holds it
// reset: synchronous; window empty, sequence counters at first_sequence, marks cleared
// depends on srsw_pkg and srsw_if
module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int WINDOW_MAX   = 8,
   parameter int SEQ_BITS     = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   srsw_req_if.sink   req_chan,
   srsw_rsp_if.source rsp_chan,
   srsw_csr_if.sink   csr_chan
);

   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int CW    = (CNT_W > 4) ? CNT_W : 4;
   localparam int OW    = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SLIDE = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [3:0]              wsize_ff, wsize_in;
   logic [7:0]              first_ff, first_in;
   logic [SEQ_BITS-1:0]     next_ff, next_in;
   logic [SEQ_BITS-1:0]     base_ff, base_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [WINDOW_MAX-1:0]   marks_ff, marks_in;

   kind_type                pend_kind_ff, pend_kind_in;
   logic [SEQ_BITS-1:0]     pend_seq_ff, pend_seq_in;
   logic [PAYLOAD_BITS-1:0] pend_pay_ff, pend_pay_in;
   logic                    pend_start_ff, pend_start_in;
   logic                    pend_stop_ff, pend_stop_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff;
   logic [SEQ_W-1:0]        rsp_seq_ff;
   logic [PAY_W-1:0]        rsp_pay_ff;
   logic                    rsp_start_ff, rsp_stop_ff, rsp_full_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   logic [PAYLOAD_BITS-1:0] mem [WINDOW_MAX];
   logic [PAYLOAD_BITS-1:0] mem_rd_ff;
   logic                    mem_we, mem_re;
   logic [PTR_W-1:0]        mem_waddr, mem_raddr;

   logic                    req_fire, csr_fire, rsp_load;
   logic [CW-1:0]           eff_window;
   logic                    full_now;
   logic [SEQ_BITS-1:0]     seq_ack, seq_tim, seq_find, offset;
   logic                    hit;
   logic [PTR_W-1:0]        idx_hit, idx_send, ptr_next;

   function automatic logic [PTR_W-1:0] wrap_idx(input logic [PTR_W-1:0] p,
                                                 input logic [PTR_W:0] a);
      logic [PTR_W:0] sum;
      sum = {1'b0, p} + a;
      if (sum >= (PTR_W+1)'(WINDOW_MAX)) begin
         sum = sum - (PTR_W+1)'(WINDOW_MAX);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      if (wsize_ff == 4'd0) begin
         eff_window = CW'(1);
      end else if (CW'(wsize_ff) > CW'(WINDOW_MAX)) begin
         eff_window = CW'(WINDOW_MAX);
      end else begin
         eff_window = CW'(wsize_ff);
      end
   end

   assign full_now = CW'(count_ff) >= eff_window;
   assign seq_ack  = SEQ_BITS'(req_chan.ack_number);
   assign seq_tim  = SEQ_BITS'(req_chan.timer_sequence);
   assign seq_find = (req_chan.mode == MODE_ACK) ? seq_ack : seq_tim;
   assign offset   = seq_find - base_ff;
   assign hit      = OW'(offset) < OW'(count_ff);
   assign idx_hit  = wrap_idx(ptr_ff, (PTR_W+1)'(offset));
   assign idx_send = wrap_idx(ptr_ff, (PTR_W+1)'(count_ff));
   assign ptr_next = wrap_idx(ptr_ff, (PTR_W+1)'(1));

   always_comb begin
      state_in      = state_ff;
      wsize_in      = wsize_ff;
      first_in      = first_ff;
      next_in       = next_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      marks_in      = marks_ff;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      pend_pay_in   = pend_pay_ff;
      pend_start_in = pend_start_ff;
      pend_stop_in  = pend_stop_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = idx_send;
      mem_raddr     = idx_hit;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_kind_in  = KIND_IGNORED;
               pend_seq_in   = '0;
               pend_pay_in   = '0;
               pend_start_in = 1'b0;
               pend_stop_in  = 1'b0;
               state_in      = ST_DONE;
               unique case (req_chan.mode)
                  MODE_SEND: begin
                     pend_seq_in = next_ff;
                     if (full_now) begin
                        pend_kind_in = KIND_REFUSED;
                     end else begin
                        mem_we             = 1'b1;
                        marks_in[idx_send] = 1'b0;
                        count_in           = count_ff + CNT_W'(1);
                        next_in            = next_ff + SEQ_BITS'(1);
                        pend_kind_in       = KIND_TRANSMIT;
                        pend_pay_in        = PAYLOAD_BITS'(req_chan.payload);
                        pend_start_in      = 1'b1;
                     end
                  end
                  MODE_ACK: begin
                     pend_seq_in = seq_ack;
                     if (req_chan.ack_checksum_ok && hit) begin
                        marks_in[idx_hit] = 1'b1;
                        pend_kind_in      = KIND_ACKED;
                        pend_stop_in      = 1'b1;
                        state_in          = ST_SLIDE;
                     end
                  end
                  MODE_TIMER: begin
                     pend_seq_in = seq_tim;
                     if (hit && !marks_ff[idx_hit]) begin
                        mem_re        = 1'b1;
                        pend_kind_in  = KIND_RETRANSMIT;
                        pend_start_in = 1'b1;
                     end
                  end
                  default: begin
                     pend_kind_in = KIND_IGNORED;
                  end
               endcase
            end
         end
         ST_SLIDE: begin
            // retire one acked front entry per cycle
            if ((count_ff != '0) && marks_ff[ptr_ff]) begin
               marks_in[ptr_ff] = 1'b0;
               ptr_in           = ptr_next;
               base_in          = base_ff + SEQ_BITS'(1);
               count_in         = count_ff - CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_fire) begin
         unique case (csr_chan.addr)
            CSR_WINDOW_SIZE: begin
               wsize_in = csr_chan.wdata[3:0];
            end
            CSR_FIRST_SEQUENCE: begin
               first_in = csr_chan.wdata;
               if (count_ff == '0) begin
                  next_in = SEQ_BITS'(csr_chan.wdata);
                  base_in = SEQ_BITS'(csr_chan.wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wsize_ff      <= WINDOW_SIZE_RESET;
         first_ff      <= FIRST_SEQUENCE_RESET;
         next_ff       <= SEQ_BITS'(FIRST_SEQUENCE_RESET);
         base_ff       <= SEQ_BITS'(FIRST_SEQUENCE_RESET);
         count_ff      <= '0;
         ptr_ff        <= '0;
         marks_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wsize_ff      <= wsize_in;
         first_ff      <= first_in;
         next_ff       <= next_in;
         base_ff       <= base_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         marks_ff      <= marks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff  <= pend_kind_in;
      pend_seq_ff   <= pend_seq_in;
      pend_pay_ff   <= pend_pay_in;
      pend_start_ff <= pend_start_in;
      pend_stop_ff  <= pend_stop_in;
      if (rsp_load) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_seq_ff   <= SEQ_W'(pend_seq_ff);
         rsp_pay_ff   <= (pend_kind_ff == KIND_RETRANSMIT) ? PAY_W'(mem_rd_ff)
                                                            : PAY_W'(pend_pay_ff);
         rsp_start_ff <= pend_start_ff;
         rsp_stop_ff  <= pend_stop_ff;
         rsp_full_ff  <= full_now;
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   // packet buffer; one transaction in flight, so a read never overlaps a write
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= PAYLOAD_BITS'(req_chan.payload);
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_kind     = rsp_kind_ff;
   assign rsp_chan.out_sequence = rsp_seq_ff;
   assign rsp_chan.out_payload  = rsp_pay_ff;
   assign rsp_chan.timer_start  = rsp_start_ff;
   assign rsp_chan.timer_stop   = rsp_stop_ff;
   assign rsp_chan.window_full  = rsp_full_ff;
   assign rsp_chan.window_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(WINDOW_MAX) >= count_ff)
      else $error("outstanding count above window capacity");

   a_front_unacked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && count_ff != '0 && pend_kind_ff == KIND_ACKED)
         |-> !marks_ff[ptr_ff])
      else $error("acked entry left at window front after slide");

   a_send_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.mode == MODE_SEND && !full_now && !csr_fire)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("accepted send did not grow the window");

endmodule

FILE: sim/selective_repeat_sender_window_tb.sv
// self-checking testbench of the selective-repeat sender window: sends, acks, timer expiries
// depends on srsw_pkg, srsw_if and selective_repeat_sender_window
`timescale 1ns / 1ps

module selective_repeat_sender_window_tb;
   import srsw_pkg::*;

   localparam int WIN_MAX        = 8;
   localparam int SETTLE_CYCLES  = 16;
   localparam int TAIL_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 120;
   localparam int HOLD_CYCLES    = 400;

   localparam csr_addr_type CSR_SPARE_LO = 2'd2;
   localparam csr_addr_type CSR_SPARE_HI = 2'd3;

   typedef struct {
      mode_type         mode;
      logic [PAY_W-1:0] payload;
      logic [SEQ_W-1:0] ack_number;
      logic             ack_ok;
      logic [SEQ_W-1:0] timer_seq;
   } send_req_type;

   typedef struct {
      kind_type           kind;
      logic [SEQ_W-1:0]   seq_num;
      logic [PAY_W-1:0]   payload;
      logic               tstart;
      logic               tstop;
      logic               full;
      logic [COUNT_W-1:0] count;
   } window_rsp_type;

   class srsw_window_scoreboard;
      logic [3:0]       window_size;
      logic [SEQ_W-1:0] first_seq;
      logic [SEQ_W-1:0] next_seq;
      logic [SEQ_W-1:0] base_seq;
      int unsigned      count;
      bit               acked[WIN_MAX];
      logic [PAY_W-1:0] packets[WIN_MAX];
      window_rsp_type   expected_q[$];
      int               errors;

      function new();
         window_size = WINDOW_SIZE_RESET;
         first_seq   = FIRST_SEQUENCE_RESET;
         next_seq    = FIRST_SEQUENCE_RESET;
         base_seq    = FIRST_SEQUENCE_RESET;
         count       = 0;
         errors      = 0;
         for (int k = 0; k < WIN_MAX; k++) begin
            acked[k]   = 1'b0;
            packets[k] = '0;
         end
      endfunction

      function int unsigned eff_window();
         if (window_size == 0) return 1;
         if (window_size > WIN_MAX) return WIN_MAX;
         return 32'(window_size);
      endfunction

      // offset from the window base, or -1 when outside the window
      function int locate(logic [SEQ_W-1:0] s);
         logic [SEQ_W-1:0] off;
         off = s - base_seq;
         if (off < count && off < WIN_MAX) return int'(off);
         return -1;
      endfunction

      function void write_reg(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
         if (addr == CSR_WINDOW_SIZE) begin
            window_size = data[3:0];
         end else if (addr == CSR_FIRST_SEQUENCE) begin
            first_seq = data;
            if (count == 0) begin
               next_seq = data;
               base_seq = data;
            end
         end
      endfunction

      function void note_request(send_req_type r);
         window_rsp_type e;
         int             idx;
         e.kind    = KIND_IGNORED;
         e.seq_num = '0;
         e.payload = '0;
         e.tstart  = 1'b0;
         e.tstop   = 1'b0;
         if (r.mode == MODE_SEND) begin
            e.seq_num = next_seq;
            if (count >= eff_window()) begin
               e.kind = KIND_REFUSED;
            end else begin
               acked[count]   = 1'b0;
               packets[count] = r.payload;
               count++;
               e.kind    = KIND_TRANSMIT;
               e.payload = r.payload;
               e.tstart  = 1'b1;
               next_seq  = next_seq + 1'b1;
            end
         end else if (r.mode == MODE_ACK) begin
            e.seq_num = r.ack_number;
            idx = locate(r.ack_number);
            if (r.ack_ok && idx >= 0) begin
               acked[idx] = 1'b1;
               e.kind  = KIND_ACKED;
               e.tstop = 1'b1;
               while (count > 0 && acked[0]) begin
                  for (int k = 0; k < WIN_MAX - 1; k++) begin
                     acked[k]   = acked[k+1];
                     packets[k] = packets[k+1];
                  end
                  acked[WIN_MAX-1]   = 1'b0;
                  packets[WIN_MAX-1] = '0;
                  count--;
                  base_seq = base_seq + 1'b1;
               end
            end
         end else if (r.mode == MODE_TIMER) begin
            e.seq_num = r.timer_seq;
            idx = locate(r.timer_seq);
            if (idx >= 0 && !acked[idx]) begin
               e.kind    = KIND_RETRANSMIT;
               e.payload = packets[idx];
               e.tstart  = 1'b1;
            end
         end
         e.full  = (count >= eff_window());
         e.count = COUNT_W'(count);
         expected_q.push_back(e);
      endfunction

      function void check_response(window_rsp_type got);
         window_rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response with no pending transaction: kind %0d seq %0d",
                   got.kind, got.seq_num);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.kind !== e.kind) begin
            $error("out_kind: expected %0d, actual %0d", e.kind, got.kind);
            errors++;
         end
         if (got.seq_num !== e.seq_num) begin
            $error("out_sequence: expected %0d, actual %0d", e.seq_num, got.seq_num);
            errors++;
         end
         if (got.payload !== e.payload) begin
            $error("out_payload: expected %h, actual %h", e.payload, got.payload);
            errors++;
         end
         if (got.tstart !== e.tstart) begin
            $error("timer_start: expected %0d, actual %0d", e.tstart, got.tstart);
            errors++;
         end
         if (got.tstop !== e.tstop) begin
            $error("timer_stop: expected %0d, actual %0d", e.tstop, got.tstop);
            errors++;
         end
         if (got.full !== e.full) begin
            $error("window_full: expected %0d, actual %0d", e.full, got.full);
            errors++;
         end
         if (got.count !== e.count) begin
            $error("window_count: expected %0d, actual %0d", e.count, got.count);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   srsw_req_if req_bus ();
   srsw_rsp_if rsp_bus ();
   srsw_csr_if csr_bus ();

   srsw_window_scoreboard sb = new();
   int reqs_taken = 0;
   int items_sent = 0;

   selective_repeat_sender_window i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #2 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic send_req_type make_req(mode_type m, logic [PAY_W-1:0] pay,
                                             logic [SEQ_W-1:0] ackn, logic ok,
                                             logic [SEQ_W-1:0] tseq);
      send_req_type r;
      r.mode       = m;
      r.payload    = pay;
      r.ack_number = ackn;
      r.ack_ok     = ok;
      r.timer_seq  = tseq;
      return r;
   endfunction

   // mostly well-formed traffic aimed at the live window, some noise
   function automatic send_req_type random_req();
      send_req_type r;
      int           pick;
      r.mode       = mode_type'($urandom_range(0, 3));
      r.payload    = $urandom;
      r.ack_number = SEQ_W'($urandom);
      r.ack_ok     = 1'($urandom);
      r.timer_seq  = SEQ_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
         r.mode = MODE_SEND;
      end else if (pick < 68) begin
         r.mode       = MODE_ACK;
         r.ack_ok     = 1'b1;
         r.ack_number = sb.base_seq + SEQ_W'($urandom_range(0, sb.count));
      end else if (pick < 78) begin
         r.mode = MODE_ACK;
      end else if (pick < 92) begin
         r.mode      = MODE_TIMER;
         r.timer_seq = sb.base_seq + SEQ_W'($urandom_range(0, sb.count));
      end else if (pick < 97) begin
         r.mode = MODE_TIMER;
      end else begin
         r.mode = MODE_NONE;
      end
      return r;
   endfunction

   task automatic push_request(send_req_type r);
      int g;
      g = (((items_sent / 64) % 3) == 0) ? 0 : gap_cycles();
      repeat (g) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.mode            = r.mode;
      req_bus.payload         = r.payload;
      req_bus.ack_number      = r.ack_number;
      req_bus.ack_checksum_ok = r.ack_ok;
      req_bus.timer_sequence  = r.timer_seq;
      req_bus.valid           = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic push_csr(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_bus.valid = 1'b0;
      csr_bus.addr  = addr;
      csr_bus.wdata = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // transaction monitor
   always @(posedge clock) begin
      window_rsp_type got;
      send_req_type   r;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.write_reg(csr_bus.addr, csr_bus.wdata);
         if (req_bus.valid && req_bus.ready) begin
            r.mode       = req_bus.mode;
            r.payload    = req_bus.payload;
            r.ack_number = req_bus.ack_number;
            r.ack_ok     = req_bus.ack_checksum_ok;
            r.timer_seq  = req_bus.timer_sequence;
            sb.note_request(r);
            reqs_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind    = rsp_bus.out_kind;
            got.seq_num = rsp_bus.out_sequence;
            got.payload = rsp_bus.out_payload;
            got.tstart  = rsp_bus.timer_start;
            got.tstop   = rsp_bus.timer_stop;
            got.full    = rsp_bus.window_full;
            got.count   = rsp_bus.window_count;
            sb.check_response(got);
         end
      end
   end

   // response side: random stalls, calm stretches, two long hold-offs
   initial begin
      int stall_left;
      int hold_left;
      int hold_stage;
      int cyc;
      int hold_at[2];
      stall_left    = 0;
      hold_left     = 0;
      hold_stage    = 0;
      cyc           = 0;
      hold_at       = '{300, 650};
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_left == 0 && hold_stage < 2 && reqs_taken >= hold_at[hold_stage]) begin
            hold_left = HOLD_CYCLES;
            hold_stage++;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (((cyc / 256) % 4) != 0 && $urandom_range(0, 99) < 25)
               stall_left = gap_cycles();
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [3:0]            ws_set[PHASES];
      logic [SEQ_W-1:0]      fs_set[PHASES];
      logic [CSR_DATA_W-1:0] wdata;
      ws_set = '{4'd1, 4'd0, 4'd15, 4'd2, 4'd9, 4'd6, 4'd3};
      fs_set = '{8'd0, 8'd255, 8'd128, 8'd200, 8'd7, 8'd64, 8'd170};

      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_NONE;
      req_bus.payload         = '0;
      req_bus.ack_number      = '0;
      req_bus.ack_checksum_ok = 1'b0;
      req_bus.timer_sequence  = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.addr            = CSR_WINDOW_SIZE;
      csr_bus.wdata           = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // empty window, fill to the reset window of four, refusal
      push_request(make_req(MODE_ACK,   '0, 8'd1, 1'b1, '0));
      push_request(make_req(MODE_TIMER, '0, '0, 1'b0, 8'd1));
      push_request(make_req(MODE_NONE,  32'hffffffff, 8'hff, 1'b1, 8'hff));
      push_request(make_req(MODE_SEND,  32'h00000000, '0, 1'b0, '0));
      push_request(make_req(MODE_SEND,  32'hffffffff, '0, 1'b0, '0));
      push_request(make_req(MODE_SEND,  32'ha5a5a5a5, '0, 1'b0, '0));
      push_request(make_req(MODE_SEND,  32'h5a5a5a5a, '0, 1'b0, '0));
      push_request(make_req(MODE_SEND,  32'h12345678, '0, 1'b0, '0));
      // retransmit, bad checksum, out of window, repeated ack, acked timer
      push_request(make_req(MODE_TIMER, '0, '0, 1'b0, 8'd2));
      push_request(make_req(MODE_ACK,   '0, 8'd1, 1'b0, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd5, 1'b1, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd2, 1'b1, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd2, 1'b1, '0));
      push_request(make_req(MODE_TIMER, '0, '0, 1'b0, 8'd2));
      push_request(make_req(MODE_TIMER, '0, '0, 1'b0, 8'd200));
      // out-of-order acks slide the base
      push_request(make_req(MODE_ACK,   '0, 8'd1, 1'b1, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd4, 1'b1, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd3, 1'b1, '0));

      // full window across the sequence wrap
      settle();
      push_csr(CSR_WINDOW_SIZE, 8'd8);
      push_csr(CSR_FIRST_SEQUENCE, 8'd254);
      for (int k = 0; k < 8; k++)
         push_request(make_req(MODE_SEND, $urandom, '0, 1'b0, '0));
      push_request(make_req(MODE_SEND,  $urandom, '0, 1'b0, '0));
      push_request(make_req(MODE_ACK,   '0, 8'd255, 1'b1, '0));
      push_request(make_req(MODE_TIMER, '0, '0, 1'b0, 8'd0));
      push_request(make_req(MODE_ACK,   '0, 8'd254, 1'b1, '0));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         wdata = {4'($urandom_range(0, 15)), ws_set[p]};
         push_csr(CSR_WINDOW_SIZE, wdata);
         if (p == 3) begin
            push_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
            push_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
         end
         push_csr(CSR_FIRST_SEQUENCE, fs_set[p]);
         for (int n = 0; n < PHASE_ITEMS; n++)
            push_request(random_req());
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
